/* src/asa_pkg.sv */
// Package with the shared types and constants of the aligned stack allocator.
`default_nettype none

package asa_pkg;

  localparam int unsigned ArenaBytesDefault = 65536;
  localparam int unsigned AlignDefault      = 16;
  localparam int unsigned PosDepthDefault   = 16;

  localparam int unsigned WordBytes = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned TopW      = 17;
  localparam int unsigned SumW      = 19;
  localparam int unsigned HdrIdxW   = 13;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_POP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  typedef enum logic {
    REG_ARENA_SIZE = 1'b0
  } reg_e;

endpackage

`default_nettype wire

/* src/aligned_stack_allocator.sv */
// Top level of the aligned stack allocator with header memory and position stack.
//
// Channel   Ports                                              Direction  Handshake
// command   start, busy, command_i, request_size_i,            in         start && !busy
//           block_address_i
// result    done_o, success_o, granted_address_o, stack_top_o  out        done_o, one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata,      in/out     APB, pready high
//           pready
//
// For each item, the accept edge reads the header and position memories,
// and the next edge applies the update, writes back and registers the result.
// done_o rises with the registered result at the update edge, and busy is low again
// in that cycle, so a new item is taken only once the last one is through.
// After reset the header memory is cleared one word per cycle, ARENA_BYTES/8 words
// (at most 8192), while busy stays high.
// The receiver cannot stall the result, so nothing waits on the output side.
`default_nettype none

module aligned_stack_allocator #(
  parameter int unsigned ARENA_BYTES = asa_pkg::ArenaBytesDefault,
  parameter int unsigned ALIGN       = asa_pkg::AlignDefault,
  parameter int unsigned POS_DEPTH   = asa_pkg::PosDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command_i,
  input  wire logic [asa_pkg::SizeW-1:0]     request_size_i,
  input  wire logic [asa_pkg::AddrW-1:0]     block_address_i,
  output logic                               done_o,
  output logic                               success_o,
  output logic [asa_pkg::AddrW-1:0]          granted_address_o,
  output logic [asa_pkg::TopW-1:0]           stack_top_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [asa_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [asa_pkg::CfgDataW-1:0]  pwdata,
  output logic [asa_pkg::CfgDataW-1:0]       prdata,
  output logic                               pready
);

  localparam int unsigned HdrWords = ARENA_BYTES / asa_pkg::WordBytes;
  localparam int unsigned HdrDepth = (HdrWords > 8192) ? 8192 : HdrWords;
  localparam int unsigned HdrAw    = $clog2(HdrDepth);
  localparam int unsigned SavedAw  = (POS_DEPTH > 1) ? $clog2(POS_DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(POS_DEPTH + 1);
  localparam int unsigned Pad      = ALIGN - 1 + asa_pkg::WordBytes;

  localparam logic [asa_pkg::SumW-1:0] PadS      = asa_pkg::SumW'(Pad);
  localparam logic [asa_pkg::SumW-1:0] AlignMask = ~asa_pkg::SumW'(ALIGN - 1);

  asa_pkg::state_e state_q, state_d;

  logic [asa_pkg::TopW-1:0]  arena_q, arena_d;
  logic [asa_pkg::TopW-1:0]  top_q, top_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [HdrAw-1:0]          clr_q, clr_d;

  asa_pkg::cmd_e             cmd_q;
  logic [asa_pkg::SizeW-1:0] req_q;
  logic [asa_pkg::AddrW-1:0] addr_q;

  logic                      done_q, done_d;
  logic                      success_q, success_d;
  logic [asa_pkg::AddrW-1:0] granted_q, granted_d;
  logic [asa_pkg::TopW-1:0]  stop_q;

  logic [asa_pkg::TopW-1:0]  hdr_mem [HdrDepth];
  logic [asa_pkg::TopW-1:0]  hdr_rdata_q;
  logic                      hdr_we;
  logic [HdrAw-1:0]          hdr_waddr;
  logic [asa_pkg::TopW-1:0]  hdr_wdata;
  logic [HdrAw-1:0]          hdr_raddr;

  logic [asa_pkg::TopW-1:0]  saved_mem [POS_DEPTH];
  logic [asa_pkg::TopW-1:0]  saved_rdata_q;
  logic                      saved_we;
  logic [SavedAw-1:0]        saved_raddr;
  logic [CntW-1:0]           cnt_m1;

  logic                      accept;
  logic                      cfg_we;
  logic [asa_pkg::TopW-1:0]  limit;

  logic [asa_pkg::SumW-1:0]  a_span, a_end, a_aligned;
  logic [asa_pkg::HdrIdxW-1:0] a_idx;
  logic                      a_ok;

  logic [asa_pkg::HdrIdxW-1:0] f_idx;
  logic [asa_pkg::TopW-1:0]  f_rest;
  logic [asa_pkg::SumW-1:0]  f_aligned;
  logic                      f_ok;

  logic                      push_ok, pop_ok;

  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready
                  && (asa_pkg::reg_e'(paddr[2]) == asa_pkg::REG_ARENA_SIZE);
  assign pready = 1'b1;
  assign prdata = (asa_pkg::reg_e'(paddr[2]) == asa_pkg::REG_ARENA_SIZE)
                  ? asa_pkg::CfgDataW'(arena_q) : '0;

  assign limit = ({15'd0, arena_q} > ARENA_BYTES) ? asa_pkg::TopW'(ARENA_BYTES) : arena_q;

  assign cnt_m1      = cnt_q - CntW'(1);
  assign saved_raddr = cnt_m1[SavedAw-1:0];
  assign f_idx       = block_address_i[asa_pkg::AddrW-1:3] - asa_pkg::HdrIdxW'(1);
  assign hdr_raddr   = f_idx[HdrAw-1:0];

  // Alloc arithmetic.
  assign a_span    = asa_pkg::SumW'(req_q) + PadS;
  assign a_end     = asa_pkg::SumW'(top_q) + a_span;
  assign a_aligned = (asa_pkg::SumW'(top_q) + PadS) & AlignMask;
  assign a_idx     = a_aligned[asa_pkg::AddrW-1:3] - asa_pkg::HdrIdxW'(1);
  assign a_ok      = (a_end <= asa_pkg::SumW'(limit))
                     && (a_aligned <= asa_pkg::SumW'(16'hFFFF))
                     && ({1'b0, a_idx} < (asa_pkg::HdrIdxW + 1)'(HdrDepth));

  // Free arithmetic on the header read at the accept edge.
  assign f_rest    = top_q - hdr_rdata_q;
  assign f_aligned = (asa_pkg::SumW'(f_rest) + PadS) & AlignMask;
  assign f_ok      = (addr_q >= asa_pkg::AddrW'(asa_pkg::WordBytes))
                     && ({1'b0, addr_q} <= limit)
                     && (addr_q[2:0] == 3'd0)
                     && ({1'b0, addr_q[asa_pkg::AddrW-1:3] - asa_pkg::HdrIdxW'(1)}
                         < (asa_pkg::HdrIdxW + 1)'(HdrDepth))
                     && (hdr_rdata_q <= top_q)
                     && (f_aligned == asa_pkg::SumW'(addr_q));

  assign push_ok = cnt_q < CntW'(POS_DEPTH);
  assign pop_ok  = cnt_q != '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      asa_pkg::ST_CLEAR: begin
        if (clr_q == HdrAw'(HdrDepth - 1)) begin
          state_d = asa_pkg::ST_IDLE;
        end
      end
      asa_pkg::ST_IDLE: begin
        if (start) begin
          state_d = asa_pkg::ST_EXEC;
        end
      end
      asa_pkg::ST_EXEC: begin
        state_d = asa_pkg::ST_IDLE;
      end
      default: begin
        state_d = asa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy      = (state_q != asa_pkg::ST_IDLE);
    arena_d   = arena_q;
    top_d     = top_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    success_d = 1'b0;
    granted_d = '0;
    hdr_we    = 1'b0;
    hdr_waddr = a_idx[HdrAw-1:0];
    hdr_wdata = a_span[asa_pkg::TopW-1:0];
    saved_we  = 1'b0;
    case (state_q)
      asa_pkg::ST_CLEAR: begin
        hdr_we    = 1'b1;
        hdr_waddr = clr_q;
        hdr_wdata = '0;
        clr_d     = clr_q + HdrAw'(1);
      end
      asa_pkg::ST_EXEC: begin
        done_d = 1'b1;
        case (cmd_q)
          asa_pkg::CMD_ALLOC: begin
            if (a_ok) begin
              success_d = 1'b1;
              granted_d = a_aligned[asa_pkg::AddrW-1:0];
              hdr_we    = 1'b1;
              top_d     = a_end[asa_pkg::TopW-1:0];
            end
          end
          asa_pkg::CMD_FREE: begin
            if (f_ok) begin
              success_d = 1'b1;
              top_d     = f_rest;
            end
          end
          asa_pkg::CMD_PUSH: begin
            if (push_ok) begin
              success_d = 1'b1;
              saved_we  = 1'b1;
              cnt_d     = cnt_q + CntW'(1);
            end
          end
          asa_pkg::CMD_POP: begin
            if (pop_ok) begin
              success_d = 1'b1;
              cnt_d     = cnt_m1;
              top_d     = saved_rdata_q;
            end
          end
          default: begin
            success_d = 1'b0;
          end
        endcase
      end
      default: begin
        busy = (state_q != asa_pkg::ST_IDLE);
      end
    endcase
    if (cfg_we) begin
      arena_d = pwdata[asa_pkg::TopW-1:0];
      top_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asa_pkg::ST_CLEAR;
      arena_q <= asa_pkg::TopW'(65536);
      top_q   <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      arena_q <= arena_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= asa_pkg::cmd_e'(command_i);
      req_q  <= request_size_i;
      addr_q <= block_address_i;
    end
    if (state_q == asa_pkg::ST_EXEC) begin
      success_q <= success_d;
      granted_q <= granted_d;
      stop_q    <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (accept) begin
      hdr_rdata_q <= hdr_mem[hdr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (saved_we) begin
      saved_mem[cnt_q[SavedAw-1:0]] <= top_q;
    end
    if (accept) begin
      saved_rdata_q <= saved_mem[saved_raddr];
    end
  end

  assign done_o            = done_q;
  assign success_o         = success_q;
  assign granted_address_o = granted_q;
  assign stack_top_o       = stop_q;

  a_done_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == asa_pkg::ST_EXEC))
    else $error("Result strobe without a preceding execute cycle.");

  a_top_within_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= limit)
    else $error("Top offset is beyond the arena limit.");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(POS_DEPTH))
    else $error("Position stack count is beyond its depth.");

  a_header_write_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_we && state_q == asa_pkg::ST_EXEC) |-> (cmd_q == asa_pkg::CMD_ALLOC && a_ok))
    else $error("Header written by a command other than a successful alloc.");

  a_busy_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asa_pkg::ST_CLEAR) |-> (busy && !done_q))
    else $error("Item handling during the header clearing pass.");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the aligned stack allocator: directed and random commands.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned HdrWords = asa_pkg::ArenaBytesDefault / asa_pkg::WordBytes;
  localparam int unsigned SpanPad = asa_pkg::AlignDefault - 1 + asa_pkg::WordBytes;
  localparam int unsigned IdleLimit = 50000;
  localparam logic [asa_pkg::CfgAddrW-1:0] ArenaSizeAddr =
    asa_pkg::CfgAddrW'(4 * asa_pkg::REG_ARENA_SIZE);

  typedef struct {
    bit        success;
    bit [15:0] granted;
    bit [16:0] top;
  } alloc_result_t;

  class alloc_scoreboard;
    int unsigned   arena_size;
    int unsigned   top_offset;
    bit [16:0]     header_words[HdrWords];
    int unsigned   saved_tops[asa_pkg::PosDepthDefault];
    int unsigned   saved_count;
    int unsigned   live_blocks[$];
    alloc_result_t expected_results[$];
    int            errors;

    function new();
      arena_size = 32'h10000;
      top_offset = 0;
      saved_count = 0;
      errors = 0;
    endfunction

    function void set_arena_size(int unsigned value);
      arena_size = value & 32'h1FFFF;
      top_offset = 0;
      saved_count = 0;
      live_blocks.delete();
    endfunction

    function int unsigned arena_limit();
      return (arena_size > asa_pkg::ArenaBytesDefault) ? asa_pkg::ArenaBytesDefault
                                                       : arena_size;
    endfunction

    function void note_command(asa_pkg::cmd_e cmd, int unsigned size, int unsigned addr);
      alloc_result_t res;
      int unsigned   span;
      int unsigned   aligned;
      int unsigned   idx;
      res.success = 1'b0;
      res.granted = '0;
      case (cmd)
        asa_pkg::CMD_ALLOC: begin
          span = SpanPad + size;
          aligned = (top_offset + SpanPad) & ~(asa_pkg::AlignDefault - 1);
          idx = (aligned - asa_pkg::WordBytes) / asa_pkg::WordBytes;
          if (top_offset + span <= arena_limit() && aligned <= 32'hFFFF && idx < HdrWords) begin
            header_words[idx] = span[16:0];
            top_offset = (top_offset + span) & 32'h1FFFF;
            res.success = 1'b1;
            res.granted = aligned[15:0];
            live_blocks.push_back(aligned);
          end
        end
        asa_pkg::CMD_FREE: begin
          if (addr >= asa_pkg::WordBytes && addr <= arena_limit() && (addr & 7) == 0) begin
            idx = (addr - asa_pkg::WordBytes) / asa_pkg::WordBytes;
            if (idx < HdrWords) begin
              span = header_words[idx];
              if (span <= top_offset) begin
                aligned = (top_offset - span + SpanPad) & ~(asa_pkg::AlignDefault - 1);
                if (aligned == addr) begin
                  top_offset -= span;
                  res.success = 1'b1;
                  if (live_blocks.size() != 0 && live_blocks[$] == addr) begin
                    void'(live_blocks.pop_back());
                  end
                end
              end
            end
          end
        end
        asa_pkg::CMD_PUSH: begin
          if (saved_count < asa_pkg::PosDepthDefault) begin
            saved_tops[saved_count] = top_offset;
            saved_count++;
            res.success = 1'b1;
          end
        end
        default: begin
          if (saved_count > 0) begin
            saved_count--;
            top_offset = saved_tops[saved_count] & 32'h1FFFF;
            res.success = 1'b1;
            while (live_blocks.size() != 0 && live_blocks[$] > top_offset) begin
              void'(live_blocks.pop_back());
            end
          end
        end
      endcase
      res.top = top_offset[16:0];
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_result(bit success, bit [15:0] granted, bit [16:0] top);
      alloc_result_t exp_res;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        exp_res = expected_results[0];
        expected_results.delete(0);
        if (success !== exp_res.success) begin
          report_mismatch($sformatf("success %0b, expected %0b", success, exp_res.success));
        end
        if (granted !== exp_res.granted) begin
          report_mismatch($sformatf("granted_address %0d, expected %0d", granted,
                                    exp_res.granted));
        end
        if (top !== exp_res.top) begin
          report_mismatch($sformatf("stack_top %0d, expected %0d", top, exp_res.top));
        end
      end
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   command_i = '0;
  logic [asa_pkg::SizeW-1:0]    request_size_i = '0;
  logic [asa_pkg::AddrW-1:0]    block_address_i = '0;
  logic                         done_o;
  logic                         success_o;
  logic [asa_pkg::AddrW-1:0]    granted_address_o;
  logic [asa_pkg::TopW-1:0]     stack_top_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [asa_pkg::CfgAddrW-1:0] paddr = '0;
  logic [asa_pkg::CfgDataW-1:0] pwdata = '0;
  logic [asa_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  alloc_scoreboard sb = new();
  int unsigned     idle_cycles = 0;

  aligned_stack_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .success_o         (success_o),
    .granted_address_o (granted_address_o),
    .stack_top_o       (stack_top_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(success_o, granted_address_o, stack_top_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_command(asa_pkg::cmd_e cmd, int unsigned size, int unsigned addr);
    start <= 1'b1;
    command_i <= cmd;
    request_size_i <= size[asa_pkg::SizeW-1:0];
    block_address_i <= addr[asa_pkg::AddrW-1:0];
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd, size & 32'h1FFFF, addr & 32'hFFFF);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_arena_size(int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ArenaSizeAddr;
    pwdata <= asa_pkg::CfgDataW'(value & 32'h1FFFF);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_arena_size(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== asa_pkg::CfgDataW'(value & 32'h1FFFF)) begin
      sb.report_mismatch($sformatf("arena_size reads %0d, expected %0d", prdata,
                                   value & 32'h1FFFF));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_mix(int unsigned count, bit quiet);
    int unsigned   issued;
    int unsigned   pick;
    int unsigned   kind;
    int unsigned   size;
    int unsigned   addr;
    bit            pushing;
    asa_pkg::cmd_e burst_cmd;
    issued = 0;
    while (issued < count) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 6));
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      size = $urandom_range(0, 131071);
      addr = $urandom_range(0, 65535);
      if (pick < 3) begin
        pushing = $urandom_range(0, 1);
        if (pushing) begin
          burst_cmd = asa_pkg::CMD_PUSH;
        end else begin
          burst_cmd = asa_pkg::CMD_POP;
        end
        repeat (asa_pkg::PosDepthDefault + 1) begin
          issue_command(burst_cmd, $urandom_range(0, 131071), $urandom_range(0, 65535));
        end
        issued += asa_pkg::PosDepthDefault + 1;
      end else if (pick < 40) begin
        if (kind < 7) begin
          size = $urandom_range(0, 48);
        end else if (kind < 9) begin
          size = $urandom_range(0, sb.arena_limit() / 2);
        end
        issue_command(asa_pkg::CMD_ALLOC, size, addr);
        issued++;
      end else if (pick < 72) begin
        if (kind < 8 && sb.live_blocks.size() != 0) begin
          addr = sb.live_blocks[$];
        end else if (kind < 9) begin
          addr = $urandom_range(0, (sb.arena_limit() + 64) / 8) * 8;
        end
        issue_command(asa_pkg::CMD_FREE, size, addr);
        issued++;
      end else if (pick < 87) begin
        issue_command(asa_pkg::CMD_PUSH, size, addr);
        issued++;
      end else begin
        issue_command(asa_pkg::CMD_POP, size, addr);
        issued++;
      end
    end
  endtask

  int unsigned phase_arena[9] = '{65536, 256, 0, 23, 4096, 131071, 1000, 65535, 65536};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);

    // The directed part runs on the reset arena size.
    issue_command(asa_pkg::CMD_POP, 0, 0);
    issue_command(asa_pkg::CMD_ALLOC, 0, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 16);
    issue_command(asa_pkg::CMD_FREE, 0, 16);
    issue_command(asa_pkg::CMD_ALLOC, 100, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 144);
    issue_command(asa_pkg::CMD_PUSH, 0, 0);
    issue_command(asa_pkg::CMD_ALLOC, 10, 0);
    issue_command(asa_pkg::CMD_ALLOC, 10, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 144);
    issue_command(asa_pkg::CMD_FREE, 0, 7);
    issue_command(asa_pkg::CMD_FREE, 0, 12);
    issue_command(asa_pkg::CMD_FREE, 0, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 65535);
    issue_command(asa_pkg::CMD_POP, 0, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 16);
    issue_command(asa_pkg::CMD_ALLOC, 65536, 0);
    issue_command(asa_pkg::CMD_ALLOC, 131071, 0);
    issue_command(asa_pkg::CMD_ALLOC, 65513, 0);
    issue_command(asa_pkg::CMD_ALLOC, 0, 0);
    issue_command(asa_pkg::CMD_PUSH, 0, 0);
    issue_command(asa_pkg::CMD_FREE, 0, 16);
    issue_command(asa_pkg::CMD_POP, 0, 0);
    issue_command(asa_pkg::CMD_POP, 0, 0);

    foreach (phase_arena[p]) begin
      wait_for_results();
      write_arena_size(phase_arena[p]);
      run_random_mix(84, p == $size(phase_arena) - 1);
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
